FILE: hdl/vadseg_pkg.sv
// Shared types, codes and constants for the voice activity segmenter.
// No dependencies; every other file in hdl/ refers to this package by scoped names.
`default_nettype none

package vadseg_pkg;

    // Field widths fixed by the interface
    localparam int PROB_W  = 16;
    localparam int BYTES_W = 16;
    localparam int LEN_W   = 20;
    localparam int CNT_W   = 21;
    localparam int CFG_W   = 20;
    localparam int IDX_W   = 3;

    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Result event codes
    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_STARTED   = 2'd1,
        EV_DISCARDED = 2'd2,
        EV_COMPLETED = 2'd3
    } ev_t;

    // Configuration register indexes
    localparam logic [IDX_W-1:0] CFG_SPEECH_THR = 3'd0;
    localparam logic [IDX_W-1:0] CFG_EXIT_THR   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PREROLL    = 3'd2;
    localparam logic [IDX_W-1:0] CFG_MAX_SEG    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_END_SIL    = 3'd4;
    localparam logic [IDX_W-1:0] CFG_MIN_SPEECH = 3'd5;
    localparam logic [IDX_W-1:0] CFG_KEPT_SIL   = 3'd6;

    // Configuration reset values
    localparam logic [PROB_W-1:0] SPEECH_THR_RST = 16'd32768;
    localparam logic [PROB_W-1:0] EXIT_THR_RST   = 16'd22938;
    localparam logic [LEN_W-1:0]  PREROLL_RST    = 20'd16000;
    localparam logic [LEN_W-1:0]  MAX_SEG_RST    = 20'd960000;
    localparam logic [LEN_W-1:0]  END_SIL_RST    = 20'd12800;
    localparam logic [LEN_W-1:0]  MIN_SPEECH_RST = 20'd4800;
    localparam logic [LEN_W-1:0]  KEPT_SIL_RST   = 20'd3200;

    typedef struct packed {
        logic [PROB_W-1:0] speech_thr;
        logic [PROB_W-1:0] exit_thr;
        logic [LEN_W-1:0]  preroll_limit;
        logic [LEN_W-1:0]  max_seg;
        logic [LEN_W-1:0]  end_sil;
        logic [LEN_W-1:0]  min_speech;
        logic [LEN_W-1:0]  kept_sil;
    } cfg_t;

    typedef struct packed {
        ev_t              ev;
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] len;
    } res_t;

    // Saturating add for the segment counters
    function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                                 input logic [CNT_W-1:0] b);
        logic [CNT_W:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        return sum[CNT_W] ? CNT_MAX : sum[CNT_W-1:0];
    endfunction

endpackage

`default_nettype wire

FILE: hdl/vad_speech_segmenter_top.sv
// Voice activity segmenter top level: configuration registers, input and result stages.
// Depends on vadseg_pkg and vadseg_core.
//
//   Channel  Direction  Handshake            Payload
//   in       sink       in_valid / in_stall  chunk_bytes, speech_prob
//   out      source     out_valid / out_stall event_res, segment_start, segment_length
//   cfg      sink       cfg_wr_en            cfg_index, cfg_wdata
//
// One item per cycle sustained while out_stall is low; each item gives exactly one result, which
// passes through the input register, then the result register after one pass of decision logic.
// The segment state advances only when an item moves into the result register.
// out_stall holds the result register; the input register then fills and in_stall rises.
// rst_n clears the valid flags and segment state and loads the configuration defaults asynchronously.
`default_nettype none

module vad_speech_segmenter_top #(
    parameter int WINDOW_SAMPLES = 512,
    parameter int RING_ADDR_BITS = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_stall,
    input  wire logic [vadseg_pkg::BYTES_W-1:0]    chunk_bytes,
    input  wire logic [vadseg_pkg::PROB_W-1:0]     speech_prob,
    output logic                                   out_valid,
    input  wire logic                              out_stall,
    output logic [1:0]                             event_res,
    output logic [vadseg_pkg::LEN_W-1:0]           segment_start,
    output logic [vadseg_pkg::LEN_W-1:0]           segment_length,
    input  wire logic                              cfg_wr_en,
    input  wire logic [vadseg_pkg::IDX_W-1:0]      cfg_index,
    input  wire logic [vadseg_pkg::CFG_W-1:0]      cfg_wdata
);

    vadseg_pkg::cfg_t cfg_reg;

    logic                           s1_valid_reg;
    logic [vadseg_pkg::BYTES_W-1:0] s1_bytes_reg;
    logic [vadseg_pkg::PROB_W-1:0]  s1_prob_reg;

    logic             out_valid_reg;
    vadseg_pkg::res_t out_reg;
    vadseg_pkg::res_t res_next;

    logic out_free;
    logic s1_adv;
    logic in_take;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.speech_thr    <= vadseg_pkg::SPEECH_THR_RST;
            cfg_reg.exit_thr      <= vadseg_pkg::EXIT_THR_RST;
            cfg_reg.preroll_limit <= vadseg_pkg::PREROLL_RST;
            cfg_reg.max_seg       <= vadseg_pkg::MAX_SEG_RST;
            cfg_reg.end_sil       <= vadseg_pkg::END_SIL_RST;
            cfg_reg.min_speech    <= vadseg_pkg::MIN_SPEECH_RST;
            cfg_reg.kept_sil      <= vadseg_pkg::KEPT_SIL_RST;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                vadseg_pkg::CFG_SPEECH_THR: cfg_reg.speech_thr    <= cfg_wdata[15:0];
                vadseg_pkg::CFG_EXIT_THR:   cfg_reg.exit_thr      <= cfg_wdata[15:0];
                vadseg_pkg::CFG_PREROLL:    cfg_reg.preroll_limit <= cfg_wdata;
                vadseg_pkg::CFG_MAX_SEG:    cfg_reg.max_seg       <= cfg_wdata;
                vadseg_pkg::CFG_END_SIL:    cfg_reg.end_sil       <= cfg_wdata;
                vadseg_pkg::CFG_MIN_SPEECH: cfg_reg.min_speech    <= cfg_wdata;
                vadseg_pkg::CFG_KEPT_SIL:   cfg_reg.kept_sil      <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake: advance the input register whenever the result register is free
    assign out_free = !out_valid_reg || !out_stall;
    assign s1_adv   = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    // Hold the accepted item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_adv)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_bytes_reg <= chunk_bytes;
            s1_prob_reg  <= speech_prob;
        end
    end

    vadseg_core #(
        .WINDOW_SAMPLES (WINDOW_SAMPLES),
        .RING_ADDR_BITS (RING_ADDR_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step_en   (s1_adv),
        .win_bytes (s1_bytes_reg),
        .win_prob  (s1_prob_reg),
        .cfg       (cfg_reg),
        .res       (res_next)
    );

    // Register the result; drop it once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_adv)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_free)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_reg <= res_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign event_res      = out_reg.ev;
    assign segment_start  = out_reg.start;
    assign segment_length = out_reg.len;

endmodule

`default_nettype wire

FILE: hdl/vadseg_core.sv
// Segmenter state and the per-window decision logic.
// Depends on vadseg_pkg; instantiated by vad_speech_segmenter_top.
`default_nettype none

module vadseg_core #(
    parameter int WINDOW_SAMPLES = 512,
    parameter int RING_ADDR_BITS = 20
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              step_en,
    input  wire logic [vadseg_pkg::BYTES_W-1:0]    win_bytes,
    input  wire logic [vadseg_pkg::PROB_W-1:0]     win_prob,
    input  wire vadseg_pkg::cfg_t                  cfg,
    output vadseg_pkg::res_t                       res
);

    localparam int LW  = vadseg_pkg::LEN_W;
    localparam int CW  = vadseg_pkg::CNT_W;
    localparam int RA  = RING_ADDR_BITS;
    localparam int SW  = (RING_ADDR_BITS > vadseg_pkg::LEN_W) ? RING_ADDR_BITS
                                                               : vadseg_pkg::LEN_W;
    localparam int WIN_BYTES = 2 * WINDOW_SAMPLES;

    localparam logic [vadseg_pkg::BYTES_W-1:0] WIN_BYTES_IN = vadseg_pkg::BYTES_W'(WIN_BYTES);
    localparam logic [RA-1:0] WIN_BYTES_RA  = RA'(WIN_BYTES);
    localparam logic [LW:0]   WIN_BYTES_PRE = (LW + 1)'(WIN_BYTES);
    localparam logic [CW-1:0] WIN_BYTES_CNT = CW'(WIN_BYTES);
    localparam logic [CW-1:0] WIN_SMP_CNT   = CW'(WINDOW_SAMPLES);

    logic          capturing_reg, capturing_next;
    logic [LW-1:0] preroll_reg, preroll_next;
    logic [CW-1:0] utt_reg, utt_next;
    logic [CW-1:0] voiced_reg, voiced_next;
    logic [CW-1:0] silence_reg, silence_next;
    logic [RA-1:0] ring_reg, ring_next;
    logic [RA-1:0] start_reg, start_next;

    logic          win_ok;
    logic [LW:0]   pre_sum;
    logic [LW-1:0] pre_new;
    logic [SW-1:0] start_diff;
    logic [RA-1:0] start_new;
    logic [CW-1:0] utt_new;
    logic [CW-1:0] voi_new;
    logic [CW-1:0] sil_new;
    logic          voiced_hit;
    logic          end_hit;
    logic          keep_seg;
    logic [LW-1:0] seg_len;
    logic [CW-1:0] excess;
    logic [CW:0]   trim;
    logic [LW-1:0] final_len;
    logic [SW-1:0] start_out_wide;
    logic [SW-1:0] start_new_wide;

    // Window arithmetic shared by both modes
    always_comb
    begin
        win_ok     = (win_bytes == WIN_BYTES_IN);
        ring_next  = ring_reg + WIN_BYTES_RA;

        pre_sum    = {1'b0, preroll_reg} + WIN_BYTES_PRE;
        pre_new    = (pre_sum > {1'b0, cfg.preroll_limit}) ? cfg.preroll_limit
                                                            : pre_sum[LW-1:0];
        start_diff = SW'(ring_next) - SW'(pre_new);
        start_new  = start_diff[RA-1:0];

        utt_new    = vadseg_pkg::sat_add(utt_reg, WIN_BYTES_CNT);
        voiced_hit = (win_prob >= cfg.exit_thr);
        voi_new    = voiced_hit ? vadseg_pkg::sat_add(voiced_reg, WIN_SMP_CNT) : voiced_reg;
        sil_new    = voiced_hit ? '0 : vadseg_pkg::sat_add(silence_reg, WIN_SMP_CNT);

        end_hit    = (utt_new >= {1'b0, cfg.max_seg}) || (sil_new >= {1'b0, cfg.end_sil});
        keep_seg   = (voi_new >= {1'b0, cfg.min_speech});

        // Truncate to the maximum, then trim trailing silence
        seg_len    = (utt_new > {1'b0, cfg.max_seg}) ? cfg.max_seg : utt_new[LW-1:0];
        excess     = (sil_new > {1'b0, cfg.kept_sil}) ? sil_new - {1'b0, cfg.kept_sil} : '0;
        trim       = {excess, 1'b0};
        final_len  = (trim > (CW + 1)'(seg_len)) ? '0 : seg_len - trim[LW-1:0];

        start_out_wide = SW'(start_reg);
        start_new_wide = SW'(start_new);
    end

    // Next state and result for one window
    always_comb
    begin
        capturing_next = capturing_reg;
        preroll_next   = preroll_reg;
        utt_next       = utt_reg;
        voiced_next    = voiced_reg;
        silence_next   = silence_reg;
        start_next     = start_reg;
        res.ev         = vadseg_pkg::EV_NONE;
        res.start      = '0;
        res.len        = '0;

        if (win_ok)
        begin
            if (!capturing_reg)
            begin
                preroll_next = pre_new;
                if (win_prob >= cfg.speech_thr)
                begin
                    capturing_next = 1'b1;
                    voiced_next    = WIN_SMP_CNT;
                    silence_next   = '0;
                    utt_next       = CW'(pre_new);
                    start_next     = start_new;
                    res.ev         = vadseg_pkg::EV_STARTED;
                    res.start      = start_new_wide[LW-1:0];
                end
            end
            else
            begin
                utt_next     = utt_new;
                voiced_next  = voi_new;
                silence_next = sil_new;
                if (end_hit)
                begin
                    capturing_next = 1'b0;
                    preroll_next   = '0;
                    utt_next       = '0;
                    voiced_next    = '0;
                    silence_next   = '0;
                    if (!keep_seg)
                    begin
                        res.ev = vadseg_pkg::EV_DISCARDED;
                    end
                    else
                    begin
                        res.ev    = vadseg_pkg::EV_COMPLETED;
                        res.start = start_out_wide[LW-1:0];
                        res.len   = final_len;
                    end
                end
            end
        end
    end

    // Advance the state once per window handed to the result stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capturing_reg <= 1'b0;
            preroll_reg   <= '0;
            utt_reg       <= '0;
            voiced_reg    <= '0;
            silence_reg   <= '0;
            ring_reg      <= '0;
            start_reg     <= '0;
        end
        else if (step_en)
        begin
            capturing_reg <= capturing_next;
            preroll_reg   <= preroll_next;
            utt_reg       <= utt_next;
            voiced_reg    <= voiced_next;
            silence_reg   <= silence_next;
            if (win_ok)
            begin
                ring_reg <= ring_next;
            end
            start_reg     <= start_next;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/vadseg_checker.sv
// Port-level checks for the voice activity segmenter, bound to the top level.
// Depends on vadseg_pkg and vad_speech_segmenter_top.
`default_nettype none

module vadseg_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           in_stall,
    input wire logic                           out_valid,
    input wire logic                           out_stall,
    input wire logic [1:0]                     event_res,
    input wire logic [vadseg_pkg::LEN_W-1:0]   segment_start,
    input wire logic [vadseg_pkg::LEN_W-1:0]   segment_length
);

    // A length is only reported on a completed segment
    a_len_only_completed: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && segment_length != '0) |-> (event_res == vadseg_pkg::EV_COMPLETED))
        else $error("segment_length set on an item that is not completed");

    // A start address is only reported on started or completed
    a_start_only_open_close: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && segment_start != '0) |->
            (event_res == vadseg_pkg::EV_STARTED || event_res == vadseg_pkg::EV_COMPLETED))
        else $error("segment_start set on a none or discarded item");

    // An empty result stage never holds back the input
    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled while no result is waiting");

    // A stalled result holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(event_res) && $stable(segment_start)
             && $stable(segment_length)))
        else $error("stalled result changed");

endmodule

bind vad_speech_segmenter_top vadseg_checker u_vadseg_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_stall       (in_stall),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .event_res      (event_res),
    .segment_start  (segment_start),
    .segment_length (segment_length)
);

`default_nettype wire
